[rtl/ihex_enc_pkg.sv]
// Shared types, character codes and the hex digit function for the
// Intel HEX record encoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ihex_enc_pkg;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_DATA  = 1'b1;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] REC_TYPE_DATA = 8'h00;

   // Character positions within one record's text
   localparam int unsigned POS_W = 4;
   localparam logic [POS_W-1:0] POS_COLON   = 4'd0;
   localparam logic [POS_W-1:0] POS_LEN_HI  = 4'd1;
   localparam logic [POS_W-1:0] POS_LEN_LO  = 4'd2;
   localparam logic [POS_W-1:0] POS_AH_HI   = 4'd3;
   localparam logic [POS_W-1:0] POS_AH_LO   = 4'd4;
   localparam logic [POS_W-1:0] POS_AL_HI   = 4'd5;
   localparam logic [POS_W-1:0] POS_AL_LO   = 4'd6;
   localparam logic [POS_W-1:0] POS_BYTE_HI = 4'd7;
   localparam logic [POS_W-1:0] POS_BYTE_LO = 4'd8;
   localparam logic [POS_W-1:0] POS_CHK_HI  = 4'd9;
   localparam logic [POS_W-1:0] POS_CHK_LO  = 4'd10;
   localparam logic [POS_W-1:0] POS_CR      = 4'd11;
   localparam logic [POS_W-1:0] POS_LF      = 4'd12;
   localparam logic [POS_W-1:0] POS_NUL     = 4'd13;

   typedef struct packed {
      logic        action;
      logic [15:0] record_address;
      logic [7:0]  record_length;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_char;
   } rsp_type;

   // One unit of text to emit: a full header, or one data byte, each
   // optionally followed by the closing checksum, CR, LF and NUL.
   typedef struct packed {
      logic [POS_W-1:0] first_pos;
      logic             close;
      logic [7:0]       len_byte;
      logic [7:0]       addr_hi;
      logic [7:0]       addr_lo;
      logic [7:0]       mid_byte;
      logic [7:0]       chk_byte;
   } job_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = 8'h30 + {4'd0, nib};
      end else begin
         c = 8'h37 + {4'd0, nib};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[rtl/ihex_enc_emit.sv]
// Job register, character sequencer and result register for the record
// encoder. Depends on ihex_enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ihex_enc_emit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                job_load,
   input  ihex_enc_pkg::job_type              job_in,
   output logic                               job_busy,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output ihex_enc_pkg::rsp_type              rsp_payload
);

   logic                             job_valid_ff, job_valid_in;
   ihex_enc_pkg::job_type            job_ff, job_in_sel;
   logic [ihex_enc_pkg::POS_W-1:0]   pos_ff, pos_in, end_pos;
   logic                             rsp_valid_ff, rsp_valid_in;
   ihex_enc_pkg::rsp_type            rsp_ff, rsp_in;
   logic                             step;
   logic                             job_done;
   logic [7:0]                       sel_byte;
   logic [3:0]                       sel_nib;
   logic [7:0]                       cur_char;

   assign end_pos  = job_ff.close ? ihex_enc_pkg::POS_NUL : ihex_enc_pkg::POS_BYTE_LO;
   assign step     = job_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign job_done = step && (pos_ff == end_pos);
   assign job_busy = job_valid_ff && !job_done;

   always_comb begin
      case (pos_ff)
         ihex_enc_pkg::POS_LEN_HI, ihex_enc_pkg::POS_LEN_LO:   sel_byte = job_ff.len_byte;
         ihex_enc_pkg::POS_AH_HI, ihex_enc_pkg::POS_AH_LO:     sel_byte = job_ff.addr_hi;
         ihex_enc_pkg::POS_AL_HI, ihex_enc_pkg::POS_AL_LO:     sel_byte = job_ff.addr_lo;
         ihex_enc_pkg::POS_BYTE_HI, ihex_enc_pkg::POS_BYTE_LO: sel_byte = job_ff.mid_byte;
         default:                                              sel_byte = job_ff.chk_byte;
      endcase
      // odd positions carry the high nibble
      sel_nib = pos_ff[0] ? sel_byte[7:4] : sel_byte[3:0];
      case (pos_ff)
         ihex_enc_pkg::POS_COLON: cur_char = ihex_enc_pkg::CHAR_COLON;
         ihex_enc_pkg::POS_CR:    cur_char = ihex_enc_pkg::CHAR_CR;
         ihex_enc_pkg::POS_LF:    cur_char = ihex_enc_pkg::CHAR_LF;
         ihex_enc_pkg::POS_NUL:   cur_char = ihex_enc_pkg::CHAR_NUL;
         default:                 cur_char = ihex_enc_pkg::hex_char(sel_nib);
      endcase
   end

   always_comb begin
      job_valid_in = job_valid_ff;
      job_in_sel   = job_ff;
      pos_in       = pos_ff;
      if (job_load) begin
         job_valid_in = 1'b1;
         job_in_sel   = job_in;
         pos_in       = job_in.first_pos;
      end else if (job_done) begin
         job_valid_in = 1'b0;
      end else if (step) begin
         pos_in = pos_ff + 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (step) begin
         rsp_valid_in     = 1'b1;
         rsp_in.out_char  = cur_char;
         rsp_in.last_char = (pos_ff == ihex_enc_pkg::POS_NUL);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff <= job_in_sel;
      pos_ff <= pos_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      job_load |-> !job_busy)
      else $error("job loaded over an unfinished job");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> pos_ff <= end_pos)
      else $error("character position ran past the end of the job");

   a_nul_ends_job: assert property (@(posedge clock) disable iff (reset)
      (step && pos_ff == ihex_enc_pkg::POS_NUL) |=> !job_valid_ff || $past(job_load))
      else $error("job still open after its terminating NUL");

endmodule

`default_nettype wire

[rtl/intel_hex_record_encoder.sv]
// Intel HEX data record encoder: one ASCII character per result transaction.
// Accepted items go to the job register, characters to the result register.
// One character per cycle unless rsp_stall holds it; a start item emits 9
// characters (14 for an empty record), a data item 2 (7 when it closes the record).
// Synchronous active-high reset clears the open record and all valid flags.
// Depends on ihex_enc_pkg and ihex_enc_emit.
`timescale 1ns / 1ps
`default_nettype none

module intel_hex_record_encoder (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  ihex_enc_pkg::req_type   req_payload,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output ihex_enc_pkg::rsp_type   rsp_payload
);

   logic [7:0]             running_sum_ff, running_sum_in;
   logic [7:0]             bytes_left_ff, bytes_left_in;
   logic                   in_record_ff, in_record_in;
   logic                   job_busy;
   logic                   accept;
   logic                   job_load;
   ihex_enc_pkg::job_type  job;
   logic [7:0]             sum_new;
   logic [7:0]             left_new;

   assign req_stall = job_busy;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      running_sum_in = running_sum_ff;
      bytes_left_in  = bytes_left_ff;
      in_record_in   = in_record_ff;
      job_load       = 1'b0;
      sum_new        = 8'd0;
      left_new       = 8'd0;

      job.first_pos = ihex_enc_pkg::POS_COLON;
      job.close     = 1'b0;
      job.len_byte  = req_payload.record_length;
      job.addr_hi   = req_payload.record_address[15:8];
      job.addr_lo   = req_payload.record_address[7:0];
      job.mid_byte  = ihex_enc_pkg::REC_TYPE_DATA;
      job.chk_byte  = 8'd0;

      if (accept) begin
         if (req_payload.action == ihex_enc_pkg::ACT_START) begin
            job_load = 1'b1;
            sum_new  = req_payload.record_length + req_payload.record_address[15:8]
                       + req_payload.record_address[7:0];
            left_new = req_payload.record_length;
         end else if (in_record_ff) begin
            // data byte inside an open record
            job_load      = 1'b1;
            job.first_pos = ihex_enc_pkg::POS_BYTE_HI;
            job.mid_byte  = req_payload.data_byte;
            sum_new       = running_sum_ff + req_payload.data_byte;
            left_new      = bytes_left_ff - 8'd1;
         end
         // data outside a record: drop it
         if (job_load) begin
            job.chk_byte = 8'd0 - sum_new;
            if (left_new == 8'd0) begin
               job.close      = 1'b1;
               running_sum_in = 8'd0;
               bytes_left_in  = 8'd0;
               in_record_in   = 1'b0;
            end else begin
               running_sum_in = sum_new;
               bytes_left_in  = left_new;
               in_record_in   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff <= 8'd0;
         bytes_left_ff  <= 8'd0;
         in_record_ff   <= 1'b0;
      end else begin
         running_sum_ff <= running_sum_in;
         bytes_left_ff  <= bytes_left_in;
         in_record_ff   <= in_record_in;
      end
   end

   ihex_enc_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .job_load    (job_load),
      .job_in      (job),
      .job_busy    (job_busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   a_open_has_bytes: assert property (@(posedge clock) disable iff (reset)
      in_record_ff |-> bytes_left_ff != 8'd0)
      else $error("record open with no data bytes left");

   a_closed_is_clear: assert property (@(posedge clock) disable iff (reset)
      !in_record_ff |-> (running_sum_ff == 8'd0 && bytes_left_ff == 8'd0))
      else $error("closed record left stale sum or count");

   a_stray_dropped: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.action == ihex_enc_pkg::ACT_DATA && !in_record_ff) |-> !job_load)
      else $error("data outside a record started a job");

endmodule

`default_nettype wire
